/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

/* sv/nmmq_pkg.sv */
// Package for the named mailbox message queue: types, codes, defaults.
// Depends on nothing.
package nmmq_pkg;
	localparam int NUM_CLIENTS_DEF   = 64;
	localparam int SLOTS_PER_BOX_DEF = 16;
	localparam int MESSAGE_BYTES_DEF = 8;
	localparam int LABEL_BYTES_DEF   = 8;

	localparam logic [2:0] MODE_CREATE  = 3'd0;
	localparam logic [2:0] MODE_SEND    = 3'd1;
	localparam logic [2:0] MODE_RECV    = 3'd2;
	localparam logic [2:0] MODE_DESTROY = 3'd3;
	localparam logic [2:0] MODE_COUNT   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_META,
		S_RDSLOT,
		S_EXEC,
		S_DONE
	} state_t;

	// Mask of the low n bytes of a 64-bit word.
	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (n > 4'(i)) begin
				m[8*i +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	// Keep bytes up to the first zero byte, at most lb bytes.
	function automatic logic [63:0] canon_name(input logic [63:0] raw, input int lb);
		logic [63:0] r;
		logic stop;
		r = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= lb || raw[8*i +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return r;
	endfunction
endpackage

/* sv/named_mailbox_message_queue_top.sv */
// Top level of the named mailbox message queue.
// Depends on nmmq_pkg.
//
// Channel   Handshake        Fields
// request   start / busy     mode caller box_name send_payload send_length max_length
// result    done (strobe)    status value recv_payload
//
// Create and send read one mailbox name per cycle from the control memory and
// compare it in the next cycle; then come the metadata read, the slot read, the
// execute step and the done strobe. Other modes pass the scan state without scanning.
// A new request is taken from the cycle after the done strobe. Reset clears only
// the state, activity flags and results; create sets up a mailbox before it is read.
// busy is high from acceptance until the done strobe; results cannot be stalled.
module named_mailbox_message_queue_top #(
	parameter int NUM_CLIENTS   = nmmq_pkg::NUM_CLIENTS_DEF,
	parameter int SLOTS_PER_BOX = nmmq_pkg::SLOTS_PER_BOX_DEF,
	parameter int MESSAGE_BYTES = nmmq_pkg::MESSAGE_BYTES_DEF,
	parameter int LABEL_BYTES   = nmmq_pkg::LABEL_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [5:0]  caller,
	input  logic [63:0] box_name,
	input  logic [63:0] send_payload,
	input  logic [3:0]  send_length,
	input  logic [3:0]  max_length,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  value,
	output logic [63:0] recv_payload
);
	import nmmq_pkg::*;

	localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int SW = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
	localparam int PW = $clog2(SLOTS_PER_BOX + 1);
	localparam int MW = CW + SW;
	localparam int TW = 64 + 2 * SW + PW;

	// Mailbox activity flags.
	logic [NUM_CLIENTS-1:0] active_q;

	// Mailbox control memory: name, read pointer, write pointer, pending count.
	logic [TW-1:0] ctrl_mem [NUM_CLIENTS];
	logic [TW-1:0] ctrl_rd_q;

	// Slot memory.
	logic [67:0] slot_mem [NUM_CLIENTS*SLOTS_PER_BOX];
	logic [67:0] slot_rd_q;

	// Request registers.
	state_t state_q, state_d;
	logic [2:0]    mode_q;
	logic [CW-1:0] who_q;
	logic          who_ok_q;
	logic [63:0]   name_q, payload_q;
	logic [3:0]    slen_q, mlen_q;
	logic [CW-1:0] scan_q;
	logic          clash_q, found_q;
	logic [CW-1:0] tgt_q;
	logic          scan_vld_s1, scan_act_s1;
	logic [CW-1:0] scan_idx_s1;
	logic          m_act_q;
	logic [1:0]    status_q;
	logic [4:0]    value_q;
	logic [63:0]   rdata_q;

	logic scan_last, scan_hit, is_scan_mode;
	logic [CW-1:0] sel, ctrl_raddr;
	logic [3:0] rlen;
	logic [SW-1:0] m_rd, m_wr;
	logic [PW-1:0] m_pend;

	// Execute outcome.
	logic [1:0]    st_d;
	logic [4:0]    val_d;
	logic [63:0]   rdat_d;
	logic          act_set, act_clr, ctrl_we, slot_we;
	logic [CW-1:0] ctrl_waddr;
	logic [TW-1:0] ctrl_wdata;

	assign is_scan_mode = (mode_q == MODE_CREATE) || (mode_q == MODE_SEND);
	assign scan_last = (scan_q == CW'(NUM_CLIENTS - 1));
	// Shared name comparator on the registered control memory read of the previous cycle.
	assign scan_hit = scan_vld_s1 && scan_act_s1 && (ctrl_rd_q[63:0] == name_q);
	assign sel = (mode_q == MODE_SEND) ? tgt_q : who_q;
	assign ctrl_raddr = (state_q == S_SCAN) ? scan_q : sel;
	assign m_rd = ctrl_rd_q[64 +: SW];
	assign m_wr = ctrl_rd_q[64 + SW +: SW];
	assign m_pend = ctrl_rd_q[64 + 2 * SW +: PW];
	assign rlen = (slot_rd_q[67:64] > mlen_q) ? mlen_q : slot_rd_q[67:64];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (start) state_d = S_SCAN;
			S_SCAN: begin
				if (!is_scan_mode) state_d = S_META;
				else if (scan_last) state_d = S_DRAIN;
			end
			S_DRAIN:  state_d = S_META;
			S_META:   state_d = S_RDSLOT;
			S_RDSLOT: state_d = S_EXEC;
			S_EXEC:   state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		status = status_q;
		value = value_q;
		recv_payload = rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture, scan and metadata fetch.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				mode_q      <= mode;
				who_q       <= CW'(caller);
				who_ok_q    <= (32'(caller) < NUM_CLIENTS);
				name_q      <= canon_name(box_name, LABEL_BYTES);
				payload_q   <= send_payload & byte_mask(send_length);
				slen_q      <= send_length;
				mlen_q      <= max_length;
				scan_q      <= '0;
				clash_q     <= 1'b0;
				found_q     <= 1'b0;
				tgt_q       <= '0;
				scan_vld_s1 <= 1'b0;
			end
			S_SCAN: begin
				if (scan_hit && scan_idx_s1 != who_q) clash_q <= 1'b1;
				if (scan_hit && !found_q) begin
					found_q <= 1'b1;
					tgt_q <= scan_idx_s1;
				end
				scan_vld_s1 <= is_scan_mode;
				scan_act_s1 <= active_q[scan_q];
				scan_idx_s1 <= scan_q;
				if (!scan_last) scan_q <= scan_q + 1'b1;
			end
			S_DRAIN: begin
				if (scan_hit && scan_idx_s1 != who_q) clash_q <= 1'b1;
				if (scan_hit && !found_q) begin
					found_q <= 1'b1;
					tgt_q <= scan_idx_s1;
				end
				scan_vld_s1 <= 1'b0;
			end
			S_META: begin
				m_act_q <= active_q[sel];
			end
			default: ;
		endcase
	end

	// Control memory read and write.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN || state_q == S_META) begin
			ctrl_rd_q <= ctrl_mem[ctrl_raddr];
		end
		if (state_q == S_EXEC && ctrl_we) begin
			ctrl_mem[ctrl_waddr] <= ctrl_wdata;
		end
	end

	// Slot memory read and write.
	always_ff @(posedge clk) begin
		if (state_q == S_RDSLOT) begin
			slot_rd_q <= slot_mem[MW'(who_q) * MW'(SLOTS_PER_BOX) + MW'(m_rd)];
		end
		if (state_q == S_EXEC && slot_we) begin
			slot_mem[MW'(tgt_q) * MW'(SLOTS_PER_BOX) + MW'(m_wr)] <= {slen_q, payload_q};
		end
	end

	// Execute: work out the result and the state update.
	always_comb begin
		st_d = ST_ERR;
		val_d = '0;
		rdat_d = '0;
		act_set = 1'b0;
		act_clr = 1'b0;
		ctrl_we = 1'b0;
		slot_we = 1'b0;
		ctrl_waddr = who_q;
		ctrl_wdata = ctrl_rd_q;
		if (who_ok_q) begin
			case (mode_q)
				MODE_CREATE: begin
					if (name_q != '0 && !m_act_q && !clash_q) begin
						act_set = 1'b1;
						ctrl_we = 1'b1;
						ctrl_wdata = '0;
						ctrl_wdata[63:0] = name_q;
						st_d = ST_OK;
					end
				end
				MODE_SEND: begin
					if (slen_q != 4'd0 && 32'(slen_q) <= MESSAGE_BYTES && found_q) begin
						if (32'(m_pend) >= SLOTS_PER_BOX) begin
							st_d = ST_FULL;
						end else begin
							slot_we = 1'b1;
							ctrl_we = 1'b1;
							ctrl_waddr = tgt_q;
							ctrl_wdata[64 + SW +: SW] = (32'(m_wr) == SLOTS_PER_BOX - 1)
								? '0 : m_wr + SW'(1);
							ctrl_wdata[64 + 2 * SW +: PW] = m_pend + PW'(1);
							st_d = ST_OK;
						end
					end
				end
				MODE_RECV: begin
					if (mlen_q != 4'd0 && m_act_q) begin
						if (m_pend == '0) begin
							st_d = ST_EMPTY;
						end else begin
							ctrl_we = 1'b1;
							ctrl_wdata[64 +: SW] = (32'(m_rd) == SLOTS_PER_BOX - 1)
								? '0 : m_rd + SW'(1);
							ctrl_wdata[64 + 2 * SW +: PW] = m_pend - PW'(1);
							val_d = 5'(rlen);
							rdat_d = slot_rd_q[63:0] & byte_mask(rlen);
							st_d = ST_OK;
						end
					end
				end
				MODE_DESTROY: begin
					if (m_act_q) begin
						act_clr = 1'b1;
						st_d = ST_OK;
					end
				end
				MODE_COUNT: begin
					if (m_act_q) begin
						val_d = 5'(m_pend);
						st_d = ST_OK;
					end
				end
				default: ;
			endcase
		end
	end

	// Result registers and activity flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			status_q <= ST_ERR;
			value_q  <= '0;
			rdata_q  <= '0;
		end else if (state_q == S_EXEC) begin
			status_q <= st_d;
			value_q  <= val_d;
			rdata_q  <= rdat_d;
			if (act_set) active_q[who_q] <= 1'b1;
			if (act_clr) active_q[who_q] <= 1'b0;
		end
	end
endmodule

/* sv/nmmq_checker.sv */
// Port-level checker for the named mailbox message queue, with its bind.
// Depends on assert_macros.svh and nmmq_pkg.
`include "assert_macros.svh"
module nmmq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [4:0]  value,
	input logic [63:0] recv_payload
);
	import nmmq_pkg::*;

	// An accepted transfer makes the block busy next cycle.
	`CHK_NEXT(a_busy, clk, arst_n, start && !busy, busy)
	// The result strobe only comes while busy, and ends it.
	`CHK_IMPL(a_done_busy, clk, arst_n, done, busy)
	`CHK_NEXT(a_done_end, clk, arst_n, done, !busy && !done)
	// A payload only accompanies a good status.
	`CHK_IMPL(a_payload, clk, arst_n, done && status != ST_OK, value == 5'd0 && recv_payload == 64'd0)
endmodule

bind named_mailbox_message_queue_top nmmq_checker u_nmmq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .value(value), .recv_payload(recv_payload)
);
